>>> sv/printf_format_engine_macros.svh
// Assertion helper macros for the printf format engine checker.
`ifndef PRINTF_FORMAT_ENGINE_MACROS_SVH
`define PRINTF_FORMAT_ENGINE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PFE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define PFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the printf format engine.
// ----------------------------------------------------------------------------
`default_nettype none
package pfe_pkg;
  localparam int MaxField    = 63;
  localparam int StrBufDepth = 64;
  localparam int MaxResults  = 64;
  localparam int SbAw        = $clog2(StrBufDepth);
  localparam int SlW         = $clog2(StrBufDepth + 1);
  localparam int FwW         = $clog2(MaxField + 1);

  localparam logic [2:0] REQ_FMT  = 3'd0;
  localparam logic [2:0] REQ_ARG  = 3'd1;
  localparam logic [2:0] REQ_SBYT = 3'd2;
  localparam logic [2:0] REQ_SEND = 3'd3;
  localparam logic [2:0] REQ_NULL = 3'd4;
  localparam logic [2:0] REQ_FEND = 3'd5;

  localparam logic [1:0] CONV_NONE = 2'd0;
  localparam logic [1:0] CONV_D    = 2'd1;
  localparam logic [1:0] CONV_X    = 2'd2;
  localparam logic [1:0] CONV_S    = 2'd3;

  // Commands from the front parser to the back emitter
  typedef enum logic [2:0] {
    CMD_CHAR,    // emit one character (literal or streamed string byte)
    CMD_NUM,     // convert and emit an integer argument
    CMD_SBUF,    // store a string byte in the buffer, maybe flush
    CMD_SFIN,    // finish a buffered string (pad and dump)
    CMD_NULL,    // null string
    CMD_FEND,    // format end marker
    CMD_NOP      // item that only changes parser state
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [7:0]       ch;
    logic [31:0]      arg;
    logic [1:0]       conv;
    logic [FwW-1:0]   width;
    logic [FwW-1:0]   prec;
    logic             prec_given;
    logic             fin;       // string not yet flushed: pad and dump it
  } cmd_t;

  localparam int CmdW = $bits(cmd_t);

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
  endfunction

  function automatic logic [7:0] null_char(input logic [2:0] i);
    case (i)
      3'd0:    null_char = 8'h28;
      3'd1:    null_char = 8'h6e;
      3'd2:    null_char = 8'h75;
      3'd3:    null_char = 8'h6c;
      3'd4:    null_char = 8'h6c;
      default: null_char = 8'h29;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> sv/printf_format_engine.sv
// ----------------------------------------------------------------------------
// printf_format_engine
// Formatter for %d, %x and %s with width and precision.
// ----------------------------------------------------------------------------
// A parser takes one input word per cycle and queues one command per word in
// a four-entry queue, so the input stalls only while that queue is full. The
// emitter runs one command at a time: a word that gives no character only
// passes through, and every character is first picked and then loaded into
// the output register. A number is converted digit by digit after a setup
// step; a buffered string is read out character by character after its
// padding spaces; a null string steps through its six characters; format end
// adds the count word. A stalled output holds the emitter where it is.
`default_nettype none
module printf_format_engine
  import pfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [7:0]  byte_value,
  input  wire logic [31:0] arg_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char,
  output logic             char_valid,
  output logic             last,
  output logic [31:0]      total_count
);
  logic cv, qfull, qne, pop;
  cmd_t cf, cq;

  pfe_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .byte_value(byte_value), .arg_value(arg_value),
    .cmd_valid(cv), .cmd_full(qfull), .cmd(cf)
  );

  pfe_queue u_queue (
    .clk(clk), .rst(rst), .push(cv), .wdata(cf), .full(qfull),
    .nonempty(qne), .pop(pop), .rdata(cq)
  );

  pfe_back u_back (
    .clk(clk), .rst(rst), .cmd_avail(qne), .cmd_in(cq), .cmd_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_char(out_char),
    .char_valid(char_valid), .last(last), .total_count(total_count)
  );
endmodule
`default_nettype wire

>>> sv/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module pfe_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front
// Format parser: tracks the spec state and turns each input word into one
// command for the emitter.
// ----------------------------------------------------------------------------
`default_nettype none
module pfe_front
  import pfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [7:0]  byte_value,
  input  wire logic [31:0] arg_value,
  output logic             cmd_valid,
  input  wire logic        cmd_full,
  output cmd_t             cmd
);
  typedef enum logic [1:0] {M_TEXT, M_SPEC, M_WARG, M_WSTR} mode_t;

  mode_t          mode;
  logic [FwW-1:0] fwidth, prec;
  logic           prec_given;
  logic [1:0]     conv;
  // Mirror of the string length seen by the emitter, for drop decisions
  logic [SlW-1:0] slen;
  logic           sflushed;

  logic           acc;
  logic [FwW-1:0] dig_src;
  logic [FwW+4:0] dig_acc;
  logic [FwW-1:0] dig_sat;

  assign in_stall = cmd_full;
  assign acc      = in_valid && !cmd_full;

  // Decimal accumulate with saturation
  always_comb begin
    dig_src = prec_given ? prec : fwidth;
    dig_acc = {5'd0, dig_src} * (FwW+5)'(10) + {(FwW+1)'(0), byte_value[3:0]};
    dig_sat = (dig_acc > (FwW+5)'(MaxField)) ? FwW'(MaxField) : dig_acc[FwW-1:0];
  end

  // Whether a string byte is kept, and whether it triggers a flush
  logic           keep;
  logic [SlW:0]   slen_inc;
  always_comb begin
    keep = !(prec_given && {1'b0, slen} >= {1'b0, (SlW)'(prec)});
    if (!sflushed && slen >= SlW'(StrBufDepth)) keep = 1'b0;
    slen_inc = {1'b0, slen} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_TEXT;
      fwidth     <= '0;
      prec       <= '0;
      prec_given <= 1'b0;
      conv       <= CONV_NONE;
      slen       <= '0;
      sflushed   <= 1'b0;
      cmd_valid  <= 1'b0;
    end else begin
      cmd_valid <= 1'b0;
      if (acc) begin
        cmd_valid      <= 1'b1;
        cmd.op         <= CMD_NOP;
        cmd.ch         <= byte_value;
        cmd.arg        <= arg_value;
        cmd.conv       <= conv;
        cmd.width      <= fwidth;
        cmd.prec       <= prec;
        cmd.prec_given <= prec_given;
        cmd.fin        <= 1'b0;
        case (req_type)
          REQ_FMT: begin
            if (mode == M_TEXT) begin
              if (byte_value == 8'h25) begin
                mode <= M_SPEC; fwidth <= '0; prec <= '0;
                prec_given <= 1'b0; conv <= CONV_NONE;
              end else begin
                cmd.op <= CMD_CHAR;
              end
            end else if (mode == M_SPEC) begin
              if (byte_value == 8'h64 || byte_value == 8'h78) begin
                conv <= (byte_value == 8'h64) ? CONV_D : CONV_X;
                mode <= M_WARG;
              end else if (byte_value == 8'h73) begin
                conv <= CONV_S; slen <= '0; sflushed <= 1'b0; mode <= M_WSTR;
              end else if (byte_value == 8'h2e) begin
                prec_given <= 1'b1; prec <= '0;
              end else if (byte_value >= 8'h30 && byte_value <= 8'h39) begin
                if (prec_given) prec <= dig_sat;
                else fwidth <= dig_sat;
              end
            end
          end
          REQ_ARG: begin
            if (mode == M_WARG) begin
              cmd.op <= CMD_NUM;
              mode <= M_TEXT; fwidth <= '0; prec <= '0;
              prec_given <= 1'b0; conv <= CONV_NONE;
            end
          end
          REQ_SBYT, REQ_SEND, REQ_NULL, REQ_FEND: begin
            if (mode == M_WSTR && req_type == REQ_NULL) begin
              if (slen == '0 && !sflushed) begin
                cmd.op <= CMD_NULL;
                mode <= M_TEXT; fwidth <= '0; prec <= '0;
                prec_given <= 1'b0; conv <= CONV_NONE;
              end
            end else if (mode == M_WSTR && req_type == REQ_SBYT && byte_value != 8'h0) begin
              if (keep) begin
                if (sflushed) begin
                  cmd.op <= CMD_CHAR;
                  if (slen != '1) slen <= slen + 1'b1;
                end else begin
                  cmd.op <= CMD_SBUF;
                  slen <= slen_inc[SlW-1:0];
                  if (slen_inc >= {1'b0, (SlW)'(fwidth)}) sflushed <= 1'b1;
                end
              end
            end else if (mode == M_WSTR && req_type != REQ_NULL) begin
              cmd.op  <= (req_type == REQ_FEND) ? CMD_FEND : CMD_SFIN;
              cmd.fin <= !sflushed;
              mode <= M_TEXT; fwidth <= '0; prec <= '0;
              prec_given <= 1'b0; conv <= CONV_NONE;
            end else if (req_type == REQ_FEND) begin
              cmd.op <= CMD_FEND;
              mode <= M_TEXT; fwidth <= '0; prec <= '0;
              prec_given <= 1'b0; conv <= CONV_NONE;
            end
          end
          default: cmd.op <= CMD_NOP;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/pfe_queue.sv
// ----------------------------------------------------------------------------
// pfe_queue
// Short command queue between the parser and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none
module pfe_queue
  import pfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      wdata,
  output logic      full,
  output logic      nonempty,
  input  wire logic pop,
  output cmd_t      rdata
);
  // Four entries of flops; pointers are two bits
  cmd_t       q [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  // Full leaves room for a command already in the parser output register
  assign full     = (cnt >= 3'd3);
  assign nonempty = (cnt != 3'd0);
  assign rdata    = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= wdata;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + {2'd0, push} - {2'd0, pop};
    end
  end
endmodule
`default_nettype wire

>>> sv/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back
// Emitter: runs one command at a time, converts numbers digit by digit,
// holds the string buffer and sends the output character words.
// ----------------------------------------------------------------------------
`default_nettype none
module pfe_back
  import pfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_avail,
  input  cmd_t             cmd_in,
  output logic             cmd_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char,
  output logic             char_valid,
  output logic             last,
  output logic [31:0]      total_count
);
  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_PAD, S_SIGN, S_ZERO, S_DIG, S_SPAD, S_SRD, S_SOUT,
    S_NULL, S_END, S_OUT
  } state_t;

  state_t      state, ret;
  cmd_t        c;
  logic [31:0] mag;
  logic [3:0]  digs [12];
  logic [3:0]  nd;
  logic        neg;
  logic [FwW:0] body;
  logic [FwW:0] pad;
  logic [FwW:0] zeros;
  logic [6:0]  nres;      // results already given for this command
  logic [31:0] ctot;
  logic [SlW-1:0] slen;
  logic [SlW-1:0] sidx;
  logic        sflushed;
  logic [2:0]  nidx;
  logic [7:0]  pend_ch;
  logic        pend_more; // more characters follow within this command

  // String buffer memory
  logic          ram_we;
  logic [SbAw-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  pfe_ram #(.Width(8), .Depth(StrBufDepth)) u_sbuf (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Decimal digit step: divide by ten via reciprocal
  logic [63:0] q_prod;
  logic [31:0] q10, r10;
  always_comb begin
    q_prod = {32'd0, mag} * 64'hCCCCCCCD;
    q10    = {3'd0, q_prod[63:35]};
    r10    = mag - q10 * 32'd10;
  end

  assign cmd_pop = (state == S_IDLE) && cmd_avail;

  // Null text byte fed as string byte
  logic [7:0] nch;
  logic       nkeep;
  logic [SlW:0] slen_inc;
  always_comb begin
    nch = null_char(nidx);
    nkeep = !(c.prec_given && {1'b0, slen} >= {1'b0, (SlW)'(c.prec)});
    slen_inc = {1'b0, slen} + 1'b1;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slen[SbAw-1:0];
    ram_wdata = c.ch;
    if (state == S_IDLE && cmd_avail && cmd_in.op == CMD_SBUF) begin
      ram_we = 1'b1; ram_wdata = cmd_in.ch;
    end else if (state == S_NULL && nkeep && !sflushed && slen < SlW'(StrBufDepth)) begin
      ram_we = 1'b1; ram_wdata = nch;
    end
    ram_raddr = sidx[SbAw-1:0];
  end

  logic can_out;
  assign can_out = !out_valid || !out_stall;

  // Output register loads a new word
  logic out_load;
  assign out_load = can_out &&
                    ((state == S_OUT && nres < 7'(MaxResults)) || state == S_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ret <= S_IDLE; out_valid <= 1'b0; ctot <= '0;
      slen <= '0; sflushed <= 1'b0; nres <= '0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (cmd_avail) begin
            c <= cmd_in; nres <= '0; sidx <= '0;
            case (cmd_in.op)
              CMD_CHAR: begin
                pend_ch <= cmd_in.ch; pend_more <= 1'b0; ret <= S_IDLE; state <= S_OUT;
                if (cmd_in.conv == CONV_S && sflushed && slen != '1) slen <= slen;
              end
              CMD_NUM: begin
                neg <= (cmd_in.conv == CONV_D) && cmd_in.arg[31];
                mag <= ((cmd_in.conv == CONV_D) && cmd_in.arg[31]) ? (32'd0 - cmd_in.arg)
                                                                     : cmd_in.arg;
                nd <= '0; state <= S_DIV;
              end
              CMD_SBUF: begin
                slen <= slen_inc[SlW-1:0];
                if (slen_inc >= {1'b0, (SlW)'(cmd_in.width)}) begin
                  sflushed <= 1'b1; state <= S_SRD;
                end
              end
              CMD_SFIN, CMD_FEND: begin
                if (cmd_in.fin) begin
                  pad <= ({1'b0, (SlW)'(cmd_in.width)} > {1'b0, slen}) ?
                         (FwW+1)'({1'b0, (SlW)'(cmd_in.width)} - {1'b0, slen}) : '0;
                  state <= S_SPAD;
                end else begin
                  state <= (cmd_in.op == CMD_FEND) ? S_END : S_IDLE;
                  slen <= '0; sflushed <= 1'b0;
                end
              end
              CMD_NULL: begin nidx <= '0; state <= S_NULL; end
              default: state <= S_IDLE;
            endcase
          end
        end
        // One digit per cycle, least significant first
        S_DIV: begin
          if (mag != 32'd0 && nd < 4'd12) begin
            digs[nd] <= (c.conv == CONV_X) ? mag[3:0] : r10[3:0];
            mag <= (c.conv == CONV_X) ? (mag >> 4) : q10;
            nd <= nd + 1'b1;
          end else begin
            if (nd == 4'd0 && !(c.prec_given && c.prec == '0)) begin
              digs[0] <= 4'd0; nd <= 4'd1;
            end else begin
              body  <= (c.prec_given && {1'b0, c.prec} > {3'd0, nd}) ?
                       {1'b0, c.prec} : (FwW+1)'(nd);
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          zeros <= body - (FwW+1)'(nd);
          if ({1'b0, c.width} > body + {{FwW{1'b0}}, neg}) begin
            pad <= {1'b0, c.width} - body - {{FwW{1'b0}}, neg};
          end else pad <= '0;
          state <= S_SIGN;
          ret <= S_SIGN;
        end
        S_SIGN: begin
          if (can_out && !out_valid || can_out) begin
            if (pad != '0) begin
              pend_ch <= 8'h20; pad <= pad - 1'b1;
              pend_more <= (pad != (FwW+1)'(1)) || neg || (zeros != '0) || (nd != '0);
              ret <= S_SIGN; state <= S_OUT;
            end else if (neg) begin
              neg <= 1'b0; pend_ch <= 8'h2d; pend_more <= (zeros != '0 || nd != '0);
              ret <= S_SIGN; state <= S_OUT;
            end else if (zeros != '0) begin
              zeros <= zeros - 1'b1; pend_ch <= 8'h30;
              pend_more <= (zeros != (FwW+1)'(1) || nd != '0);
              ret <= S_SIGN; state <= S_OUT;
            end else if (nd != '0) begin
              nd <= nd - 1'b1; pend_ch <= hex_char(digs[nd - 1'b1]);
              pend_more <= (nd != 4'd1); ret <= S_SIGN; state <= S_OUT;
            end else state <= S_IDLE;
          end
        end
        // Padding before a buffered string, then dump the buffer
        S_SPAD: begin
          if (pad != '0) begin
            pad <= pad - 1'b1; pend_ch <= 8'h20;
            pend_more <= (pad != (FwW+1)'(1)) || (slen != '0) || (c.op == CMD_FEND);
            ret <= S_SPAD; state <= S_OUT;
          end else state <= S_SRD;
        end
        S_SRD: begin
          if (sidx < slen) state <= S_SOUT;
          else begin
            if (c.op == CMD_SBUF) state <= S_IDLE;
            else begin
              slen <= '0; sflushed <= 1'b0;
              state <= (c.op == CMD_FEND) ? S_END : S_IDLE;
            end
          end
        end
        // After a null flush, kept null characters may still follow
        S_SOUT: begin
          pend_ch <= ram_rdata; sidx <= sidx + 1'b1;
          pend_more <= (sidx + 1'b1 < slen) || (c.op == CMD_FEND) ||
                       (c.op == CMD_NULL && nidx != 3'd6 && nkeep);
          ret <= S_SRD; state <= S_OUT;
        end
        // Feed (null) through the string byte rules
        S_NULL: begin
          if (nidx == 3'd6) begin
            if (!sflushed) begin
              pad <= ({1'b0, (SlW)'(c.width)} > {1'b0, slen}) ?
                     (FwW+1)'({1'b0, (SlW)'(c.width)} - {1'b0, slen}) : '0;
              c.op <= CMD_SFIN; state <= S_SPAD;
            end else begin
              slen <= '0; sflushed <= 1'b0; state <= S_IDLE;
            end
          end else begin
            nidx <= nidx + 1'b1;
            if (nkeep && !sflushed && slen < SlW'(StrBufDepth)) begin
              slen <= slen_inc[SlW-1:0];
              if (slen_inc >= {1'b0, (SlW)'(c.width)}) begin
                sflushed <= 1'b1; sidx <= '0;
                c.op <= CMD_NULL; state <= S_SRD;
              end
            end else if (nkeep && sflushed) begin
              pend_ch <= nch;
              pend_more <= (nidx != 3'd5) &&
                           !(c.prec_given && slen_inc >= {1'b0, (SlW)'(c.prec)});
              ret <= S_NULL; state <= S_OUT;
              slen <= slen + 1'b1;
            end
          end
        end
        S_END: begin
          if (can_out) begin
            out_char <= 8'h0; char_valid <= 1'b0;
            last <= 1'b1; total_count <= ctot; ctot <= '0; state <= S_IDLE;
          end
        end
        // Send one character word while the result limit for this command is not reached
        S_OUT: begin
          if (can_out) begin
            if (nres < 7'(MaxResults)) begin
              out_char <= pend_ch; char_valid <= 1'b1;
              last <= !pend_more; total_count <= ctot + 1'b1; ctot <= ctot + 1'b1;
              nres <= nres + 1'b1;
            end
            state <= (ret == S_SRD && c.op == CMD_NULL && sidx >= slen) ? S_NULL : ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/pfe_checker.sv
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks of the printf format engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "printf_format_engine_macros.svh"
module pfe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        char_valid,
  input wire logic        last,
  input wire logic [7:0]  out_char,
  input wire logic [31:0] total_count
);
  `PFE_ASSERT(a_end_last, out_valid && !char_valid, last, "end word not last")
  `PFE_ASSERT(a_end_zero, out_valid && !char_valid, out_char == 8'h0, "end char")
  `PFE_ASSERT(a_cnt_nz, out_valid && char_valid, total_count != 32'd0, "count zero")
  `PFE_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_char),
                   "stalled word changed")
endmodule

bind printf_format_engine pfe_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .char_valid(char_valid), .last(last), .out_char(out_char),
  .total_count(total_count)
);
`default_nettype wire

>>> verif/printf_format_engine_tb.sv
// ----------------------------------------------------------------------------
// printf_format_engine_tb
// Self-checking bench: drives format, argument and string words, predicts
// every output character and the format-end count, and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Scoreboard: holds the formatter state and the queue of expected words
class fmt_scoreboard;
  typedef struct packed {
    logic [7:0]  ch;
    logic        cv;
    logic        lst;
    logic [31:0] cnt;
  } out_word_t;

  typedef enum int {M_TEXT, M_SPEC, M_WARG, M_WSTR} mode_t;

  out_word_t   pending[$];
  int          errors;
  mode_t       mode;
  int unsigned fwidth, prec;
  bit          prec_on;
  logic [1:0]  conv;
  logic [7:0]  sbuf[64];
  int unsigned slen;
  bit          flushed;
  logic [31:0] total;
  int          nres;

  function new();
    errors = 0;
    mode = M_TEXT;
    total = 0;
    clear_spec();
  endfunction

  function void clear_spec();
    fwidth = 0;
    prec = 0;
    prec_on = 0;
    conv = pfe_pkg::CONV_NONE;
    slen = 0;
    flushed = 0;
  endfunction

  function void put_char(logic [7:0] c);
    out_word_t w;
    if (nres >= pfe_pkg::MaxResults) return;
    total = total + 1;
    w.ch = c;
    w.cv = 1;
    w.lst = 0;
    w.cnt = total;
    pending.push_back(w);
    nres++;
  endfunction

  function void pad_to(int unsigned used);
    while (used < fwidth) begin
      put_char(8'h20);
      used++;
    end
  endfunction

  function void put_number(logic [31:0] a);
    logic [31:0] mag;
    logic [7:0]  digs[12];
    int unsigned nd, body, base;
    bit          neg;
    mag = a;
    neg = 0;
    nd = 0;
    base = (conv == pfe_pkg::CONV_X) ? 16 : 10;
    if (conv == pfe_pkg::CONV_D && a[31]) begin
      neg = 1;
      mag = -a;
    end
    while (mag != 0) begin
      digs[nd] = 8'((mag % base < 10) ? 32'h30 + mag % base : 32'h57 + mag % base);
      nd++;
      mag = mag / base;
    end
    if (nd == 0 && !(prec_on && prec == 0)) begin
      digs[0] = 8'h30;
      nd = 1;
    end
    body = (prec_on && prec > nd) ? prec : nd;
    pad_to(body + neg);
    if (neg) put_char(8'h2d);
    for (int i = nd; i < body; i++) put_char(8'h30);
    while (nd > 0) begin
      nd--;
      put_char(digs[nd]);
    end
  endfunction

  function void str_byte(logic [7:0] b);
    if (prec_on && slen >= prec) return;
    if (flushed) begin
      put_char(b);
      slen++;
      return;
    end
    if (slen >= 64) return;
    sbuf[slen] = b;
    slen++;
    if (slen >= fwidth) begin
      for (int i = 0; i < slen; i++) put_char(sbuf[i]);
      flushed = 1;
    end
  endfunction

  function void finish_string();
    if (!flushed) begin
      pad_to(slen);
      for (int i = 0; i < slen; i++) put_char(sbuf[i]);
    end
    clear_spec();
    mode = M_TEXT;
  endfunction

  function void format_byte(logic [7:0] b);
    if (mode == M_TEXT) begin
      if (b == "%") begin
        clear_spec();
        mode = M_SPEC;
      end else put_char(b);
      return;
    end
    if (mode != M_SPEC) return;
    if (b == "d" || b == "x") begin
      conv = (b == "d") ? pfe_pkg::CONV_D : pfe_pkg::CONV_X;
      mode = M_WARG;
    end else if (b == "s") begin
      conv = pfe_pkg::CONV_S;
      slen = 0;
      flushed = 0;
      mode = M_WSTR;
    end else if (b == ".") begin
      prec_on = 1;
      prec = 0;
    end else if (b >= "0" && b <= "9") begin
      if (prec_on) prec = (prec * 10 + b - "0" > 63) ? 63 : prec * 10 + b - "0";
      else fwidth = (fwidth * 10 + b - "0" > 63) ? 63 : fwidth * 10 + b - "0";
    end
  endfunction

  // Note an accepted input word and queue what it should produce
  function void note_input(logic [2:0] t, logic [7:0] b, logic [31:0] a);
    out_word_t w;
    int base;
    base = pending.size();
    nres = 0;
    case (t)
      pfe_pkg::REQ_FMT: format_byte(b);
      pfe_pkg::REQ_ARG:
        if (mode == M_WARG) begin
          put_number(a);
          clear_spec();
          mode = M_TEXT;
        end
      pfe_pkg::REQ_SBYT:
        if (mode == M_WSTR) begin
          if (b == 0) finish_string();
          else str_byte(b);
        end
      pfe_pkg::REQ_SEND: if (mode == M_WSTR) finish_string();
      pfe_pkg::REQ_NULL:
        if (mode == M_WSTR && slen == 0 && !flushed) begin
          for (int i = 0; i < 6; i++) str_byte(pfe_pkg::null_char(3'(i)) );
          finish_string();
        end
      pfe_pkg::REQ_FEND: begin
        if (mode == M_WSTR) finish_string();
        if (nres >= pfe_pkg::MaxResults) void'(pending.pop_back());
        w.ch = 0;
        w.cv = 0;
        w.lst = 0;
        w.cnt = total;
        pending.push_back(w);
        total = 0;
        clear_spec();
        mode = M_TEXT;
      end
      default: ;
    endcase
    if (pending.size() > base) pending[pending.size() - 1].lst = 1;
  endfunction

  // Compare one accepted output word with the oldest expectation
  function void check_output(logic [7:0] c, logic cv, logic lst, logic [31:0] cnt);
    out_word_t e;
    if (pending.size() == 0) begin
      $display("%0t unexpected word: char %h valid %b last %b count %0d",
               $time, c, cv, lst, cnt);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e.ch !== c) begin
      $display("%0t out_char: expected %h actual %h", $time, e.ch, c);
      errors++;
    end
    if (e.cv !== cv) begin
      $display("%0t char_valid: expected %b actual %b", $time, e.cv, cv);
      errors++;
    end
    if (e.lst !== lst) begin
      $display("%0t last: expected %b actual %b", $time, e.lst, lst);
      errors++;
    end
    if (e.cnt !== cnt) begin
      $display("%0t total_count: expected %0d actual %0d", $time, e.cnt, cnt);
      errors++;
    end
  endfunction
endclass

module printf_format_engine_tb;
  import pfe_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  req_type;
  logic [7:0]  byte_value;
  logic [31:0] arg_value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_char;
  logic        char_valid;
  logic        last;
  logic [31:0] total_count;

  fmt_scoreboard fmt_sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  recv_hold;

  printf_format_engine uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .byte_value(byte_value), .arg_value(arg_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char(out_char), .char_valid(char_valid), .last(last),
    .total_count(total_count)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Output side: random stalls, optional long hold, check on accept
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        fmt_sb.check_output(out_char, char_valid, last, total_count);
      out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Send one word; idles first at random, holds until accepted.
  // The caller drops valid, by the next word or by a drain.
  task automatic send_word(input logic [2:0] t, input logic [7:0] b,
                           input logic [31:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= t;
    byte_value <= b;
    arg_value <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fmt_sb.note_input(t, b, a);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(REQ_FMT, s[i], $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fmt_sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_arg();
    case ($urandom_range(5))
      0: return 0;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return $urandom_range(999);
      default: return $urandom;
    endcase
  endfunction

  // One random spec plus its argument or string, with some noise
  task automatic random_spec();
    int n;
    if ($urandom_range(3) == 0) send_word(REQ_FMT, 8'(32'h20 + $urandom_range(90)), 0);
    send_word(REQ_FMT, "%", 0);
    if ($urandom_range(1)) send_word(REQ_FMT, 8'("0" + $urandom_range(9)), 0);
    if ($urandom_range(3) == 0) send_word(REQ_FMT, 8'("0" + $urandom_range(9)), 0);
    if ($urandom_range(1)) begin
      send_word(REQ_FMT, ".", 0);
      if ($urandom_range(2)) send_word(REQ_FMT, 8'("0" + $urandom_range(9)), 0);
    end
    if ($urandom_range(9) == 0)
      send_word(3'($urandom_range(7)), 8'($urandom), $urandom);
    case ($urandom_range(2))
      0: begin
        send_word(REQ_FMT, "d", 0);
        send_word(REQ_ARG, 8'($urandom), rand_arg());
      end
      1: begin
        send_word(REQ_FMT, "x", 0);
        send_word(REQ_ARG, 8'($urandom), rand_arg());
      end
      default: begin
        send_word(REQ_FMT, "s", 0);
        if ($urandom_range(5) == 0) send_word(REQ_NULL, 8'($urandom), $urandom);
        n = $urandom_range(8);
        for (int i = 0; i < n; i++)
          send_word(REQ_SBYT, 8'(1 + $urandom_range(254)), $urandom);
        case ($urandom_range(4))
          0: send_word(REQ_SBYT, 0, $urandom);
          1: send_word(REQ_FEND, 8'($urandom), $urandom);
          default: send_word(REQ_SEND, 8'($urandom), $urandom);
        endcase
      end
    endcase
    if ($urandom_range(9) == 0) send_word(REQ_FEND, 8'($urandom), $urandom);
  endtask

  initial begin
    fmt_sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = '0;
    byte_value = '0;
    arg_value = '0;
    recv_hold = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every conversion, null string, wrong-state words
    send_text("A%5d");
    send_word(REQ_ARG, 0, 32'h8000_0000);
    send_text("%.0x");
    send_word(REQ_ARG, 0, 0);
    send_text("%99.99x");
    send_word(REQ_ARG, 0, 32'hffff_ffff);
    send_text("%8.3s");
    send_word(REQ_NULL, 8'hff, 0);
    send_text("%1.s");
    send_word(REQ_SBYT, 8'hff, 0);
    send_word(REQ_SEND, 0, 0);
    send_word(3'd7, 8'hff, 32'hffff_ffff);
    send_word(REQ_FEND, 0, 0);
    drain();

    // Random phases with swapped idling, then none
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 81 : 0;
      recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 32 : 0;
      for (int k = 0; k < 6; k++) random_spec();
      send_word(REQ_FEND, 0, 0);
      if (ph == 1) drain();
    end

    // Long receiver hold while the sender keeps going
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int k = 0; k < 6; k++) random_spec();
    join
    send_word(REQ_FEND, 0, 0);
    drain();

    if (fmt_sb.errors == 0 && fmt_sb.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/pfe_pkg.sv
sv/pfe_ram.sv
sv/pfe_front.sv
sv/pfe_queue.sv
sv/pfe_back.sv
sv/printf_format_engine.sv
sv/pfe_checker.sv
verif/printf_format_engine_tb.sv
